@@ sv/lee_grid_router_defines.svh @@
// Assertion macros shared by the router checker
`ifndef LEE_GRID_ROUTER_DEFINES_SVH
`define LEE_GRID_ROUTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LGR_CHK_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LGR_CHK_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/lgr_pkg.sv @@
// Types and constants shared by the grid router modules
`default_nettype none
package lgr_pkg;

	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 64;

	localparam logic [3:0] LABEL_FIRST = 4'd1;
	localparam logic [3:0] LABEL_TOP   = 4'd9;
	localparam logic [6:0] GRID_RESET  = 7'd64;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_ROUTE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic {
		REG_GRID_COLS = 1'b0,
		REG_GRID_ROWS = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_R_INIT,
		ST_W_START,
		ST_F_RD,
		ST_F_GET,
		ST_N_RD,
		ST_N_CHK,
		ST_W_END,
		ST_T_INIT,
		ST_T_CHK,
		ST_T_RD,
		ST_T_CAP,
		ST_T_DEC,
		ST_T_H2,
		ST_CLR,
		ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_SWEEP_ALL,
		OP_SWEEP_LAB,
		OP_WR_CELL,
		OP_RD_CELL,
		OP_R_INIT,
		OP_W_START,
		OP_F_RD,
		OP_F_GET,
		OP_N_RD,
		OP_N_SKIP,
		OP_N_CHK,
		OP_W_SWAP,
		OP_T_INIT,
		OP_T_RD,
		OP_T_CAP,
		OP_T_DEC,
		OP_T_H2,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} lgr_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic ends_in;
		logic f_end;
		logic nb_in;
		logic k_last;
		logic nxt_zero;
		logic found;
		logic t_home;
		logic t_got;
		logic j_last;
		logic out_free;
	} lgr_sts_t;

endpackage
`default_nettype wire

@@ sv/lee_grid_router.sv @@
// Top level of the Lee maze router: sequencer plus grid datapath
//
//  channel | signals                               | moves
//  in      | in_valid / in_stall                   | one request: write, route or read
//  out     | out_valid / out_stall                 | one result per request
//  cfg     | cfg_valid / cfg_ready, index, data    | grid_cols, grid_rows
//
// Write and read pass through their access state and then DONE; a bad command goes to DONE.
// Route: per frontier cell, one label/flag memory access per on-grid neighbour; per
// trace-back step, label reads of the cell and its four neighbours; then a clear of all labels.
// After reset a sweep over all MAX_COLS*MAX_ROWS cells clears the grid; in_stall stays high.
// One request at a time; a finished result waits in the output register under out_stall.
`default_nettype none
module lee_grid_router import lgr_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [5:0]  src_x,
	input  logic [5:0]  src_y,
	input  logic [5:0]  dst_x,
	input  logic [5:0]  dst_y,
	input  logic        layer,
	input  logic        set_blocked,
	input  logic        set_keepout,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        routed,
	output logic [11:0] path_length,
	output logic        cell_blocked,
	output logic        cell_keepout,
	output logic        cell_wire_one,
	output logic        cell_halo_one,
	output logic        cell_wire_two,
	output logic        cell_halo_two,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	lgr_cmd_t ctl;
	lgr_sts_t sts;

	assign cfg_ready = 1'b1;

	lgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	lgr_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.src_x         (src_x),
		.src_y         (src_y),
		.dst_x         (dst_x),
		.dst_y         (dst_y),
		.layer         (layer),
		.set_blocked   (set_blocked),
		.set_keepout   (set_keepout),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.routed        (routed),
		.path_length   (path_length),
		.cell_blocked  (cell_blocked),
		.cell_keepout  (cell_keepout),
		.cell_wire_one (cell_wire_one),
		.cell_halo_one (cell_halo_one),
		.cell_wire_two (cell_wire_two),
		.cell_halo_two (cell_halo_two)
	);

endmodule
`default_nettype wire

@@ sv/lgr_ctrl.sv @@
// Sequencer for the grid router: state machine driving datapath operations
`default_nettype none
module lgr_ctrl import lgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] command,
	input  lgr_sts_t   sts,
	output logic       in_stall,
	output lgr_cmd_t   ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl.op  = OP_NOP;
		case (state_q)
			ST_SWEEP: begin
				ctl.op = OP_SWEEP_ALL;
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctl.op = OP_LOAD;
					case (command)
						CMD_WRITE: state_d = ST_WR;
						CMD_ROUTE: state_d = ST_R_INIT;
						CMD_READ:  state_d = ST_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_WR: begin
				ctl.op  = OP_WR_CELL;
				state_d = ST_DONE;
			end
			ST_RD: begin
				ctl.op  = OP_RD_CELL;
				state_d = ST_DONE;
			end
			ST_R_INIT: begin
				if (sts.ends_in) begin
					ctl.op  = OP_R_INIT;
					state_d = ST_W_START;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_W_START: begin
				ctl.op  = OP_W_START;
				state_d = ST_F_RD;
			end
			ST_F_RD: begin
				if (sts.f_end) begin
					state_d = ST_W_END;
				end else begin
					ctl.op  = OP_F_RD;
					state_d = ST_F_GET;
				end
			end
			ST_F_GET: begin
				ctl.op  = OP_F_GET;
				state_d = ST_N_RD;
			end
			ST_N_RD: begin
				if (sts.nb_in) begin
					ctl.op  = OP_N_RD;
					state_d = ST_N_CHK;
				end else begin
					ctl.op  = OP_N_SKIP;
					state_d = sts.k_last ? ST_F_RD : ST_N_RD;
				end
			end
			ST_N_CHK: begin
				ctl.op  = OP_N_CHK;
				state_d = sts.k_last ? ST_F_RD : ST_N_RD;
			end
			ST_W_END: begin
				if (sts.nxt_zero) begin
					state_d = ST_CLR;
				end else if (sts.found) begin
					state_d = ST_T_INIT;
				end else begin
					ctl.op  = OP_W_SWAP;
					state_d = ST_W_START;
				end
			end
			ST_T_INIT: begin
				ctl.op  = OP_T_INIT;
				state_d = ST_T_CHK;
			end
			ST_T_CHK: begin
				state_d = sts.t_home ? ST_CLR : ST_T_RD;
			end
			ST_T_RD: begin
				ctl.op  = OP_T_RD;
				state_d = ST_T_CAP;
			end
			ST_T_CAP: begin
				ctl.op  = OP_T_CAP;
				state_d = sts.j_last ? ST_T_DEC : ST_T_RD;
			end
			ST_T_DEC: begin
				if (sts.t_got) begin
					ctl.op  = OP_T_DEC;
					state_d = ST_T_H2;
				end else begin
					state_d = ST_CLR;
				end
			end
			ST_T_H2: begin
				ctl.op  = OP_T_H2;
				state_d = ST_T_CHK;
			end
			ST_CLR: begin
				ctl.op = OP_SWEEP_LAB;
				if (sts.sweep_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_SWEEP;
		endcase
	end

endmodule
`default_nettype wire

@@ sv/lgr_dp.sv @@
// Router datapath: grid flag memories, wave labels, frontier lists, trace-back
`default_nettype none
module lgr_dp import lgr_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lgr_cmd_t    ctl,
	output lgr_sts_t    sts,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic [1:0]  command,
	input  logic [5:0]  src_x,
	input  logic [5:0]  src_y,
	input  logic [5:0]  dst_x,
	input  logic [5:0]  dst_y,
	input  logic        layer,
	input  logic        set_blocked,
	input  logic        set_keepout,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        routed,
	output logic [11:0] path_length,
	output logic        cell_blocked,
	output logic        cell_keepout,
	output logic        cell_wire_one,
	output logic        cell_halo_one,
	output logic        cell_wire_two,
	output logic        cell_halo_two
);

	localparam int NC  = MAX_COLS * MAX_ROWS;
	localparam int AW  = $clog2(NC);
	localparam int NCW = $clog2(NC + 1);
	localparam int XW  = $clog2(MAX_COLS);
	localparam int YW  = $clog2(MAX_ROWS);
	localparam int FW  = XW + YW;
	localparam int CLW = $clog2(MAX_COLS + 1);
	localparam int RLW = $clog2(MAX_ROWS + 1);
	localparam int XCW = (CLW > 6) ? CLW : 6;
	localparam int YCW = (RLW > 6) ? RLW : 6;

	typedef enum logic [1:0] {DIR_UP, DIR_DN, DIR_RT, DIR_LF} dir_t;

	function automatic logic [AW-1:0] cell_addr(input logic [XCW-1:0] x,
		input logic [YCW-1:0] y);
		return AW'(AW'(y) * MAX_COLS + AW'(x));
	endfunction

	dp_op_t op;
	assign op = ctl.op;

	// configuration
	logic [6:0]     cols_q, rows_q;
	logic [CLW-1:0] ncols;
	logic [RLW-1:0] nrows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= GRID_RESET;
			rows_q <= GRID_RESET;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_GRID_COLS: cols_q <= cfg_data;
				REG_GRID_ROWS: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cols_q == '0)            ncols = CLW'(1);
		else if (cols_q > MAX_COLS)  ncols = CLW'(MAX_COLS);
		else                         ncols = CLW'(cols_q);
		if (rows_q == '0)            nrows = RLW'(1);
		else if (rows_q > MAX_ROWS)  nrows = RLW'(MAX_ROWS);
		else                         nrows = RLW'(rows_q);
	end

	// captured request
	logic [1:0] cmd_q;
	logic [5:0] sx_q, sy_q, tx_q, ty_q;
	logic       layer_q, sb_q, sk_q;

	logic [XCW-1:0] sx, tx;
	logic [YCW-1:0] sy, ty;
	logic           src_in, dst_in;
	logic [AW-1:0]  src_addr;

	assign sx       = XCW'(sx_q);
	assign sy       = YCW'(sy_q);
	assign tx       = XCW'(tx_q);
	assign ty       = YCW'(ty_q);
	assign src_in   = (sx < ncols) && (sy < nrows);
	assign dst_in   = (tx < ncols) && (ty < nrows);
	assign src_addr = cell_addr(sx, sy);

	// control registers
	logic [AW-1:0]  swp_q;
	logic [NCW-1:0] i_q, ncur_q, nnext_q, len_q;
	logic [1:0]     k_q;
	logic [2:0]     j_q;
	logic [3:0]     wave_q;
	logic           sel_q, found_q, vert_q, routed_q, out_valid_q;

	// payload registers
	logic [XCW-1:0] fx_q, cx_q, nx_q;
	logic [YCW-1:0] fy_q, cy_q, ny_q;
	logic [3:0]     labs_q [5];
	logic           pt_in_q;

	// memories
	logic [3:0]    lab_mem [NC];
	logic [1:0]    bk_mem  [NC];
	logic          w1_mem  [NC];
	logic          h1_mem  [NC];
	logic          w2_mem  [NC];
	logic          h2_mem  [NC];
	logic [FW-1:0] fr0_mem [NC];
	logic [FW-1:0] fr1_mem [NC];

	logic [3:0]    lab_rd_q;
	logic [1:0]    bk_rd_q;
	logic          w1_rd_q, h1_rd_q, w2_rd_q, h2_rd_q;
	logic [FW-1:0] fr0_rd_q, fr1_rd_q;

	logic sweeping, sweep_all, sweep_last;
	assign sweep_all  = (op == OP_SWEEP_ALL);
	assign sweeping   = sweep_all || (op == OP_SWEEP_LAB);
	assign sweep_last = (swp_q == AW'(NC - 1));

	// neighbour k of the frontier cell: right, left, up, down
	logic [XCW-1:0] nbx;
	logic [YCW-1:0] nby;
	logic           nb_neg, nb_in, nb_ok, nb_tgt, push;
	logic [AW-1:0]  nb_addr;

	always_comb begin
		nbx    = fx_q;
		nby    = fy_q;
		nb_neg = 1'b0;
		case (k_q)
			2'd0: nbx = fx_q + 1'b1;
			2'd1: begin
				nbx    = fx_q - 1'b1;
				nb_neg = (fx_q == '0);
			end
			2'd2: nby = fy_q + 1'b1;
			2'd3: begin
				nby    = fy_q - 1'b1;
				nb_neg = (fy_q == '0);
			end
			default: ;
		endcase
	end

	assign nb_in   = !nb_neg && (nbx < ncols) && (nby < nrows);
	assign nb_addr = cell_addr(nbx, nby);
	assign nb_tgt  = (nbx == tx) && (nby == ty);
	assign nb_ok   = (lab_rd_q == '0) && (bk_rd_q == '0) &&
		!(layer_q ? (w2_rd_q | h2_rd_q) : (w1_rd_q | h1_rd_q));
	assign push    = (op == OP_N_CHK) && nb_ok && (nnext_q != NCW'(NC));

	// trace-back probe j: here, up, down, right, left
	logic [XCW-1:0] ptx;
	logic [YCW-1:0] pty;
	logic           pt_neg, pt_in;

	always_comb begin
		ptx    = cx_q;
		pty    = cy_q;
		pt_neg = 1'b0;
		case (j_q)
			3'd1: pty = cy_q + 1'b1;
			3'd2: begin
				pty    = cy_q - 1'b1;
				pt_neg = (cy_q == '0);
			end
			3'd3: ptx = cx_q + 1'b1;
			3'd4: begin
				ptx    = cx_q - 1'b1;
				pt_neg = (cx_q == '0);
			end
			default: ;
		endcase
	end

	assign pt_in = !pt_neg && (ptx < ncols) && (pty < nrows);

	// step choice: stay vertical while running vertically
	logic [3:0]     want;
	dir_t           dir;
	logic           got, nvert;
	logic [XCW-1:0] mvx, hax, hbx;
	logic [YCW-1:0] mvy, hay, hby;
	logic           ha_in, hb_in, hb_neg;

	assign want = (labs_q[0] <= LABEL_FIRST) ? LABEL_TOP : labs_q[0] - 4'd1;

	always_comb begin
		got = 1'b1;
		dir = DIR_UP;
		if (vert_q && labs_q[1] == want)      dir = DIR_UP;
		else if (vert_q && labs_q[2] == want) dir = DIR_DN;
		else if (labs_q[3] == want)           dir = DIR_RT;
		else if (labs_q[4] == want)           dir = DIR_LF;
		else if (labs_q[1] == want)           dir = DIR_UP;
		else if (labs_q[2] == want)           dir = DIR_DN;
		else                                  got = 1'b0;
	end

	assign nvert = (dir == DIR_UP) || (dir == DIR_DN);

	always_comb begin
		mvx = cx_q;
		mvy = cy_q;
		case (dir)
			DIR_UP: mvy = cy_q + 1'b1;
			DIR_DN: mvy = cy_q - 1'b1;
			DIR_RT: mvx = cx_q + 1'b1;
			DIR_LF: mvx = cx_q - 1'b1;
			default: ;
		endcase
	end

	// halos sit across the run; first side on T_DEC, second on T_H2
	assign hax    = nvert ? cx_q + 1'b1 : cx_q;
	assign hay    = nvert ? cy_q : cy_q + 1'b1;
	assign ha_in  = (hax < ncols) && (hay < nrows);
	assign hbx    = vert_q ? cx_q - 1'b1 : cx_q;
	assign hby    = vert_q ? cy_q : cy_q - 1'b1;
	assign hb_neg = vert_q ? (cx_q == '0) : (cy_q == '0);
	assign hb_in  = !hb_neg && (hbx < ncols) && (hby < nrows);

	// memory port muxing
	logic          lab_we, lab_re, flag_re, bk_we, w_we, h_we, fr0_we, fr1_we;
	logic [AW-1:0] lab_wa, lab_ra, flag_ra, bk_wa, w_wa, h_wa, fr0_wa;
	logic [3:0]    lab_wd;
	logic [1:0]    bk_wd;
	logic [FW-1:0] fr0_wd, src_ent, nb_ent;

	assign src_ent = {YW'(sy_q), XW'(sx_q)};
	assign nb_ent  = {nby[YW-1:0], nbx[XW-1:0]};

	always_comb begin
		lab_we = 1'b0;
		lab_wa = swp_q;
		lab_wd = '0;
		case (op)
			OP_SWEEP_ALL, OP_SWEEP_LAB: lab_we = 1'b1;
			OP_R_INIT: begin
				lab_we = 1'b1;
				lab_wa = src_addr;
				lab_wd = LABEL_FIRST;
			end
			OP_N_CHK: begin
				lab_we = push;
				lab_wa = nb_addr;
				lab_wd = wave_q;
			end
			default: ;
		endcase
	end

	assign lab_re  = (op == OP_N_RD) || (op == OP_T_RD);
	assign lab_ra  = (op == OP_T_RD) ? cell_addr(ptx, pty) : nb_addr;
	assign flag_re = (op == OP_N_RD) || (op == OP_RD_CELL);
	assign flag_ra = (op == OP_RD_CELL) ? src_addr : nb_addr;

	assign bk_we = sweep_all || ((op == OP_WR_CELL) && src_in);
	assign bk_wa = sweep_all ? swp_q : src_addr;
	assign bk_wd = sweep_all ? 2'b00 : {sb_q, sk_q};

	assign w_we = sweep_all || (op == OP_T_DEC);
	assign w_wa = sweep_all ? swp_q : cell_addr(cx_q, cy_q);
	assign h_we = sweep_all || ((op == OP_T_DEC) && ha_in) || ((op == OP_T_H2) && hb_in);
	assign h_wa = sweep_all ? swp_q :
		(op == OP_T_DEC) ? cell_addr(hax, hay) : cell_addr(hbx, hby);

	// frontier ping-pong: sel_q picks the list being expanded
	assign fr0_we = (op == OP_R_INIT) || (push && sel_q);
	assign fr1_we = push && !sel_q;
	assign fr0_wa = (op == OP_R_INIT) ? '0 : nnext_q[AW-1:0];
	assign fr0_wd = (op == OP_R_INIT) ? src_ent : nb_ent;

	always_ff @(posedge clk) begin
		if (lab_we) lab_mem[lab_wa] <= lab_wd;
		if (lab_re) lab_rd_q <= lab_mem[lab_ra];
	end

	always_ff @(posedge clk) begin
		if (bk_we) bk_mem[bk_wa] <= bk_wd;
		if (flag_re) bk_rd_q <= bk_mem[flag_ra];
	end

	always_ff @(posedge clk) begin
		if (w_we && (sweep_all || !layer_q)) w1_mem[w_wa] <= !sweep_all;
		if (flag_re) w1_rd_q <= w1_mem[flag_ra];
	end

	always_ff @(posedge clk) begin
		if (w_we && (sweep_all || layer_q)) w2_mem[w_wa] <= !sweep_all;
		if (flag_re) w2_rd_q <= w2_mem[flag_ra];
	end

	always_ff @(posedge clk) begin
		if (h_we && (sweep_all || !layer_q)) h1_mem[h_wa] <= !sweep_all;
		if (flag_re) h1_rd_q <= h1_mem[flag_ra];
	end

	always_ff @(posedge clk) begin
		if (h_we && (sweep_all || layer_q)) h2_mem[h_wa] <= !sweep_all;
		if (flag_re) h2_rd_q <= h2_mem[flag_ra];
	end

	always_ff @(posedge clk) begin
		if (fr0_we) fr0_mem[fr0_wa] <= fr0_wd;
		if (op == OP_F_RD) fr0_rd_q <= fr0_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fr1_we) fr1_mem[nnext_q[AW-1:0]] <= nb_ent;
		if (op == OP_F_RD) fr1_rd_q <= fr1_mem[i_q[AW-1:0]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_q       <= '0;
			i_q         <= '0;
			ncur_q      <= '0;
			nnext_q     <= '0;
			len_q       <= '0;
			k_q         <= '0;
			j_q         <= '0;
			wave_q      <= LABEL_FIRST;
			sel_q       <= 1'b0;
			found_q     <= 1'b0;
			vert_q      <= 1'b1;
			routed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sweeping) swp_q <= sweep_last ? '0 : swp_q + 1'b1;
			if (op == OP_OUT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (op)
				OP_LOAD: begin
					routed_q <= 1'b0;
					len_q    <= '0;
				end
				OP_R_INIT: begin
					ncur_q  <= NCW'(1);
					wave_q  <= LABEL_FIRST;
					found_q <= 1'b0;
					sel_q   <= 1'b0;
				end
				OP_W_START: begin
					wave_q  <= (wave_q == LABEL_TOP) ? LABEL_FIRST : wave_q + 4'd1;
					nnext_q <= '0;
					i_q     <= '0;
				end
				OP_F_GET: k_q <= '0;
				OP_N_SKIP, OP_N_CHK: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) i_q <= i_q + 1'b1;
					if (push) begin
						nnext_q <= nnext_q + 1'b1;
						if (nb_tgt) found_q <= 1'b1;
					end
				end
				OP_W_SWAP: begin
					sel_q  <= !sel_q;
					ncur_q <= nnext_q;
				end
				OP_T_INIT: begin
					vert_q   <= 1'b1;
					len_q    <= '0;
					j_q      <= '0;
					routed_q <= 1'b1;
				end
				OP_T_CAP: j_q <= j_q + 3'd1;
				OP_T_DEC: vert_q <= nvert;
				OP_T_H2: begin
					len_q <= len_q + 1'b1;
					j_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q   <= command;
				sx_q    <= src_x;
				sy_q    <= src_y;
				tx_q    <= dst_x;
				ty_q    <= dst_y;
				layer_q <= layer;
				sb_q    <= set_blocked;
				sk_q    <= set_keepout;
			end
			OP_F_GET: begin
				fx_q <= XCW'(sel_q ? fr1_rd_q[XW-1:0] : fr0_rd_q[XW-1:0]);
				fy_q <= YCW'(sel_q ? fr1_rd_q[FW-1:XW] : fr0_rd_q[FW-1:XW]);
			end
			OP_T_INIT: begin
				cx_q <= tx;
				cy_q <= ty;
			end
			OP_T_RD: pt_in_q <= pt_in;
			OP_T_CAP: labs_q[j_q] <= pt_in_q ? lab_rd_q : 4'd0;
			OP_T_DEC: begin
				nx_q <= mvx;
				ny_q <= mvy;
			end
			OP_T_H2: begin
				cx_q <= nx_q;
				cy_q <= ny_q;
			end
			default: ;
		endcase
	end

	// result register
	logic rd_hit;
	assign rd_hit = (cmd_q == CMD_READ) && src_in;

	always_ff @(posedge clk) begin
		if (op == OP_OUT) begin
			routed        <= routed_q;
			path_length   <= 12'(len_q);
			cell_blocked  <= rd_hit & bk_rd_q[1];
			cell_keepout  <= rd_hit & bk_rd_q[0];
			cell_wire_one <= rd_hit & w1_rd_q;
			cell_halo_one <= rd_hit & h1_rd_q;
			cell_wire_two <= rd_hit & w2_rd_q;
			cell_halo_two <= rd_hit & h2_rd_q;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.sweep_last = sweep_last;
	assign sts.ends_in    = src_in && dst_in;
	assign sts.f_end      = (i_q == ncur_q);
	assign sts.nb_in      = nb_in;
	assign sts.k_last     = (k_q == 2'd3);
	assign sts.nxt_zero   = (nnext_q == '0);
	assign sts.found      = found_q;
	assign sts.t_home     = ((cx_q == sx) && (cy_q == sy)) || (len_q == NCW'(NC));
	assign sts.t_got      = got;
	assign sts.j_last     = (j_q == 3'd4);
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

@@ sv/lgr_checker.sv @@
// Port-level checks for the grid router, bound to the top level
`default_nettype none
`include "lee_grid_router_defines.svh"
module lgr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire        routed,
	input wire [11:0] path_length,
	input wire        cell_blocked,
	input wire        cell_keepout,
	input wire        cell_wire_one,
	input wire        cell_halo_one,
	input wire        cell_wire_two,
	input wire        cell_halo_two
);

	`LGR_CHK_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(routed) && $stable(path_length), "result changed while stalled")
	`LGR_CHK_NOW(a_fail_len, out_valid && !routed, path_length == 12'd0, "failed route reports a length")
	`LGR_CHK_NOW(a_route_flags, out_valid && routed, !cell_blocked && !cell_keepout && !cell_wire_one && !cell_halo_one && !cell_wire_two && !cell_halo_two, "route result carries cell flags")
	`LGR_CHK_NXT(a_busy, in_valid && !in_stall, in_stall, "second request taken while busy")

endmodule

bind lee_grid_router lgr_checker u_lgr_checker (.*);
`default_nettype wire

@@ tb/tb_lee_grid_router.sv @@
// Self-checking testbench for the Lee grid router: directed and random requests
`timescale 1ns / 1ps
`default_nettype none
module tb_lee_grid_router;
	import lgr_pkg::*;

	localparam int GW = 64;
	localparam int GH = 64;
	localparam int NC = GW * GH;
	localparam logic [1:0] CMD_NONE = 2'd3;	// unused code, must do nothing
	localparam int STALL_LIMIT = 500000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic        routed;
		logic [11:0] path_length;
		logic        blocked;
		logic        keepout;
		logic        wire_one;
		logic        halo_one;
		logic        wire_two;
		logic        halo_two;
	} grid_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic [5:0] src_x = '0, src_y = '0, dst_x = '0, dst_y = '0;
	logic layer = 1'b0, set_blocked = 1'b0, set_keepout = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic routed;
	logic [11:0] path_length;
	logic cell_blocked, cell_keepout, cell_wire_one, cell_halo_one;
	logic cell_wire_two, cell_halo_two;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [6:0] cfg_data = '0;

	lee_grid_router dut (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// grid state mirror
	bit blk_m[NC], ko_m[NC], w1_m[NC], h1_m[NC], w2_m[NC], h2_m[NC], seen_m[NC];
	logic [3:0] wave_m[NC];
	int front_cur[NC], front_nxt[NC];
	logic [6:0] cols_reg = 7'd64, rows_reg = 7'd64;

	grid_result_t pending_results[$];
	int errors = 0;
	int n_checked = 0, n_routed = 0, n_unrouted = 0, n_reads = 0, n_sent = 0;
	int burst_left = 0;

	function automatic int cols_eff();
		return (cols_reg < 1) ? 1 : (cols_reg > GW) ? GW : int'(cols_reg);
	endfunction

	function automatic int rows_eff();
		return (rows_reg < 1) ? 1 : (rows_reg > GH) ? GH : int'(rows_reg);
	endfunction

	function automatic bit on_grid(int x, int y);
		return x >= 0 && y >= 0 && x < cols_eff() && y < rows_eff();
	endfunction

	function automatic logic [3:0] wave_at(int x, int y);
		return on_grid(x, y) ? wave_m[y * GW + x] : 4'd0;
	endfunction

	// free cell on this layer; marks it seen when taken
	function automatic bit can_enter(int x, int y, bit ly);
		int c;
		if (!on_grid(x, y))
			return 0;
		c = y * GW + x;
		if (wave_m[c] != 0 || blk_m[c] || ko_m[c] || seen_m[c])
			return 0;
		if (!ly && (w1_m[c] || h1_m[c]))
			return 0;
		if (ly && (w2_m[c] || h2_m[c]))
			return 0;
		seen_m[c] = 1;
		return 1;
	endfunction

	function automatic void put_halo(int x, int y, bit ly);
		if (!on_grid(x, y))
			return;
		if (!ly)
			h1_m[y * GW + x] = 1;
		else
			h2_m[y * GW + x] = 1;
	endfunction

	function automatic void wipe_wave();
		foreach (wave_m[i]) begin
			wave_m[i] = 4'd0;
			seen_m[i] = 0;
		end
	endfunction

	// wave expansion and trace-back; -1 when no path
	function automatic int route_len(int sx, int sy, int tx, int ty, bit ly);
		int dxs[4] = '{1, -1, 0, 0};
		int dys[4] = '{0, 0, 1, -1};
		int ncur, nnext, tgt, cx, cy, nx, ny, x, y, len;
		logic [3:0] wave, here, want;
		bit found, vert, got;
		if (!on_grid(sx, sy) || !on_grid(tx, ty))
			return -1;
		tgt = ty * GW + tx;
		ncur = 1;
		front_cur[0] = sy * GW + sx;
		wave_m[sy * GW + sx] = LABEL_FIRST;
		wave = LABEL_FIRST;
		found = 0;
		while (!found) begin
			wave = (wave == LABEL_TOP) ? LABEL_FIRST : wave + 4'd1;
			nnext = 0;
			for (int i = 0; i < ncur; i++) begin
				x = front_cur[i] % GW;
				y = front_cur[i] / GW;
				for (int k = 0; k < 4; k++) begin
					if (nnext < NC && can_enter(x + dxs[k], y + dys[k], ly)) begin
						front_nxt[nnext] = (y + dys[k]) * GW + x + dxs[k];
						nnext++;
					end
				end
			end
			if (nnext == 0) begin
				wipe_wave();
				return -1;
			end
			for (int i = 0; i < nnext; i++) begin
				wave_m[front_nxt[i]] = wave;
				if (front_nxt[i] == tgt)
					found = 1;
				front_cur[i] = front_nxt[i];
			end
			ncur = nnext;
		end
		cx = tx;
		cy = ty;
		len = 0;
		vert = 1;
		while (!(cx == sx && cy == sy) && len < NC) begin
			here = wave_at(cx, cy);
			want = (here <= 4'd1) ? LABEL_TOP : here - 4'd1;
			nx = cx;
			ny = cy;
			got = 0;
			if (vert) begin
				if (wave_at(cx, cy + 1) == want) begin
					ny = cy + 1; got = 1;
				end else if (wave_at(cx, cy - 1) == want) begin
					ny = cy - 1; got = 1;
				end
			end
			if (!got) begin
				if (wave_at(cx + 1, cy) == want) begin
					nx = cx + 1; got = 1;
				end else if (wave_at(cx - 1, cy) == want) begin
					nx = cx - 1; got = 1;
				end else if (wave_at(cx, cy + 1) == want) begin
					ny = cy + 1; got = 1;
				end else if (wave_at(cx, cy - 1) == want) begin
					ny = cy - 1; got = 1;
				end
			end
			if (!got)
				break;
			if (nx == cx)
				vert = 1;
			if (ny == cy)
				vert = 0;
			if (!ly)
				w1_m[cy * GW + cx] = 1;
			else
				w2_m[cy * GW + cx] = 1;
			if (vert) begin
				put_halo(cx + 1, cy, ly);
				put_halo(cx - 1, cy, ly);
			end else begin
				put_halo(cx, cy + 1, ly);
				put_halo(cx, cy - 1, ly);
			end
			len++;
			cx = nx;
			cy = ny;
		end
		wipe_wave();
		return len;
	endfunction

	function automatic grid_result_t grid_predict(logic [1:0] cmd, int sx, int sy, int tx,
			int ty, bit ly, bit b, bit ko);
		grid_result_t r;
		int len, c;
		r = '0;
		c = sy * GW + sx;
		case (cmd)
			CMD_WRITE: begin
				if (on_grid(sx, sy)) begin
					blk_m[c] = b;
					ko_m[c] = ko;
				end
			end
			CMD_ROUTE: begin
				len = route_len(sx, sy, tx, ty, ly);
				if (len >= 0) begin
					r.routed = 1'b1;
					r.path_length = len[11:0];
				end
			end
			CMD_READ: begin
				if (on_grid(sx, sy)) begin
					r.blocked = blk_m[c];
					r.keepout = ko_m[c];
					r.wire_one = w1_m[c];
					r.halo_one = h1_m[c];
					r.wire_two = w2_m[c];
					r.halo_two = h2_m[c];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// sender: one request, bursts and gaps between them
	task automatic send_req(logic [1:0] cmd, int sx, int sy, int tx = 0, int ty = 0,
			bit ly = 0, bit b = 0, bit ko = 0);
		@(negedge clk);
		command <= cmd;
		src_x <= sx[5:0];
		src_y <= sy[5:0];
		dst_x <= tx[5:0];
		dst_y <= ty[5:0];
		layer <= ly;
		set_blocked <= b;
		set_keepout <= ko;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.insert(pending_results.size(),
			grid_predict(cmd, sx, sy, tx, ty, ly, b, ko));
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 6))
				@(negedge clk);
			burst_left = $urandom_range(0, 8);
		end
	endtask

	// hold off until every expected result has come, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [6:0] val);
		drain();
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_GRID_COLS)
			cols_reg = val;
		else
			rows_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_grid(logic [6:0] c, logic [6:0] r);
		write_reg(REG_GRID_COLS, c);
		write_reg(REG_GRID_ROWS, r);
	endtask

	task automatic test_directed();
		set_grid(7'd8, 7'd8);
		send_req(CMD_WRITE, 0, 0, 0, 0, 0, 1, 1);
		send_req(CMD_READ, 0, 0);
		send_req(CMD_WRITE, 63, 63, 0, 0, 0, 1, 1);	// off grid: ignored
		send_req(CMD_READ, 63, 63);
		send_req(CMD_ROUTE, 2, 2, 2, 2, 0);		// source equals target
		send_req(CMD_ROUTE, 1, 1, 40, 1, 1);	// target off grid
		send_req(CMD_ROUTE, 1, 1, 63, 63, 0);
		send_req(CMD_ROUTE, 0, 7, 7, 7, 0);		// along top edge, halo clipped
		send_req(CMD_READ, 3, 6);
		send_req(CMD_READ, 3, 7);
		send_req(CMD_ROUTE, 7, 0, 7, 7, 1);		// right edge on metal two
		send_req(CMD_READ, 6, 3);
		// wall in the blocked corner source: frontier dies at once
		send_req(CMD_WRITE, 1, 0, 0, 0, 0, 0, 1);
		send_req(CMD_WRITE, 0, 1, 0, 0, 0, 1, 0);
		send_req(CMD_ROUTE, 0, 0, 5, 5, 0);
		send_req(CMD_NONE, 63, 63, 63, 63, 1, 1, 1);
		send_req(CMD_WRITE, 3, 3, 0, 0, 0, 0, 1);
		send_req(CMD_ROUTE, 3, 3, 5, 4, 1);		// keepout source still routes
		send_req(CMD_READ, 5, 4);
		send_req(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0);
		send_req(CMD_READ, 0, 0);
	endtask

	task automatic test_random(int n, int cols, int rows, int route_pct);
		int pick, sx, sy;
		set_grid(cols[6:0], rows[6:0]);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			// mostly on the grid, now and then anywhere in the 6-bit range
			sx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, (cols > 64 ? 64 : cols) - 1);
			sy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, (rows > 64 ? 64 : rows) - 1);
			if (pick < route_pct)
				send_req(CMD_ROUTE, sx, sy, $urandom_range(0, (cols > 64 ? 64 : cols) - 1),
					$urandom_range(0, (rows > 64 ? 64 : rows) - 1),
					1'($urandom_range(0, 1)));
			else if (pick < route_pct + 30)
				send_req(CMD_WRITE, sx, sy, 0, 0, 0, $urandom_range(0, 3) == 0,
					$urandom_range(0, 4) == 0);
			else if (pick < 96)
				send_req(CMD_READ, sx, sy);
			else
				send_req(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 63),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			if ($urandom_range(0, 14) == 0)
				drain();
		end
	endtask

	task automatic test_grid_limits();
		set_grid(7'd0, 7'd0);	// acts as one cell
		send_req(CMD_ROUTE, 0, 0, 0, 0, 0);
		send_req(CMD_WRITE, 0, 0, 0, 0, 0, 1, 0);
		send_req(CMD_READ, 0, 0);
		send_req(CMD_READ, 1, 0);
		set_grid(7'd64, 7'd1);
		send_req(CMD_ROUTE, 0, 0, 63, 0, 1);
		send_req(CMD_READ, 63, 0);
		set_grid(7'd127, 7'd127);	// clipped to the full grid
		send_req(CMD_ROUTE, 0, 0, 63, 63, 0);
		send_req(CMD_ROUTE, 63, 0, 0, 63, 1);
		send_req(CMD_READ, 63, 63);
		test_random(12, 64, 64, 0);
	endtask

	// receiver stall pattern: quiet, light and heavy stretches
	int stall_mode = 0, stall_span = 0;
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_span = $urandom_range(5, 60);
		end else begin
			stall_span--;
		end
		out_stall <= (stall_mode == 0) ? 1'b0 :
			($urandom_range(0, stall_mode == 1 ? 5 : 1) == 0);
	end

	always @(posedge clk) begin
		grid_result_t exp_r, got_r;
		if (arst_n && out_valid && !out_stall) begin
			got_r = '{routed, path_length, cell_blocked, cell_keepout, cell_wire_one,
				cell_halo_one, cell_wire_two, cell_halo_two};
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", got_r);
			end else begin
				exp_r = pending_results.pop_front();
				n_checked++;
				if (exp_r.routed)
					n_routed++;
				if (got_r.routed !== exp_r.routed || got_r.path_length !== exp_r.path_length
						|| got_r.blocked !== exp_r.blocked || got_r.keepout !== exp_r.keepout
						|| got_r.wire_one !== exp_r.wire_one
						|| got_r.halo_one !== exp_r.halo_one
						|| got_r.wire_two !== exp_r.wire_two
						|| got_r.halo_two !== exp_r.halo_two) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p got %p", exp_r, got_r);
				end
			end
		end
	end

	int idle_count = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		wipe_wave();
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(45, 12, 10, 35);
		test_random(25, 5, 16, 40);
		test_grid_limits();
		drain();
		if (pending_results.size() != 0)
			errors++;
		$display("%0d requests sent, %0d results checked, %0d routes connected",
			n_sent, n_checked, n_routed);
		$display("grids from one cell to 64x64, both layers, edge and blocked cases");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
